/* src/sebs_pkg.sv */
// Shared types and constants for the binarized Sobel edge stream.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sebs_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int MIN_SIZE       = 3;

    localparam int PIX_W    = 8;
    localparam int THR_W    = 8;
    localparam int FW_W     = 12;
    localparam int FH_W     = 13;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int SUM_W    = PIX_W + 2;
    localparam int SQ_W     = 2 * SUM_W;

    localparam int QDEPTH   = 8;
    localparam int QAW      = $clog2(QDEPTH);
    localparam int QCW      = $clog2(QDEPTH + 1);

    localparam logic [THR_W-1:0] THR_RESET    = 8'd128;
    localparam logic [FW_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [FH_W-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [PIX_W-1:0] EDGE_ON      = 8'hFF;
    localparam logic [PIX_W-1:0] EDGE_OFF     = 8'h00;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        PICK_PREV = 2'd0,
        PICK_EDGE = 2'd1,
        PICK_LAST = 2'd2
    } t_pick;

    typedef struct packed {
        logic [THR_W-1:0] edge_threshold;
        logic [FW_W-1:0]  frame_width;
        logic [FH_W-1:0]  frame_height;
    } t_cfg;

    // One accepted pixel: up to three results, expanded by the back end.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             edge_hit;
        logic             has_prev;
        logic             has_edge;
        logic             has_last;
        logic             last_px;
    } t_rec;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           nempty;
    } t_qstat;

endpackage

`default_nettype wire

/* src/sobel_edge_binarize_stream.sv */
// Top level of the binarized Sobel edge stream: register port, front, queue, back.
// Depends on sebs_pkg, sebs_front, sebs_queue and sebs_back.
//
// Grey pixels enter in raster order on i_valid / o_stall / i_pixel_value; an item
// is taken at a clock edge with i_valid high and o_stall low. Results leave on
// o_valid / i_stall with edge value (0 or 255), column, row and frame-last flag;
// a result is taken at an edge with o_valid high and i_stall low.
// One pixel per cycle is accepted while o_stall is low. Each pixel gives up to
// three results, one per cycle out while i_stall is low: the result for a pixel
// appears while the next row streams in, and the bottom row is emitted alongside
// the last input row, so that row runs at half rate. The first result of a pixel
// is formed through the line store read at the accepting edge, then gradient,
// square, threshold into the queue and the output register. o_stall rises when
// queue records plus pixels in the three pipeline stages reach the eight-entry
// depth; a stalled receiver fills the queue and then holds the input. The user
// must write threshold, width and height over the APB port only while idle; the
// block does not enforce it. Reset clears counters, pipeline and queue, not the line store.
`default_nettype none

module sobel_edge_binarize_stream
    import sebs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_pixel_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_edge_value,
    output logic [COL_W-1:0]  o_out_column,
    output logic [ROW_W-1:0]  o_out_row,
    output logic              o_frame_last
);

    t_cfg   r_cfg;
    logic   cfg_wr;
    logic   push, pop;
    t_rec   push_rec, head_rec;
    t_qstat q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_threshold <= THR_RESET;
            r_cfg.frame_width    <= WIDTH_RESET;
            r_cfg.frame_height   <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_THRESHOLD: r_cfg.edge_threshold <= pwdata[THR_W-1:0];
                REG_WIDTH:     r_cfg.frame_width    <= pwdata[FW_W-1:0];
                REG_HEIGHT:    r_cfg.frame_height   <= pwdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_THRESHOLD: prdata = DATA_W'(r_cfg.edge_threshold);
            REG_WIDTH:     prdata = DATA_W'(r_cfg.frame_width);
            REG_HEIGHT:    prdata = DATA_W'(r_cfg.frame_height);
            default:       prdata = '0;
        endcase
    end

    sebs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .i_qstat       (q_stat),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    sebs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_qstat (q_stat)
    );

    sebs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_rec),
        .i_qstat      (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_edge_value (o_edge_value),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(q_stat.count) <= QDEPTH)
        else $error("record queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (int'(q_stat.count) < QDEPTH) || pop)
        else $error("record pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.nempty)
        else $error("record popped from an empty queue");

    a_last_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> (o_edge_value == EDGE_OFF))
        else $error("frame-last result marked as edge");
`endif

endmodule

`default_nettype wire

/* src/sebs_front.sv */
// Front end: position counters, paired line store, 3x3 window, gradient and threshold.
// Emits one record into the queue for each pixel that has a result; depends on sebs_pkg.
`default_nettype none

module sebs_front
    import sebs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_value,
    input  t_qstat           i_qstat,
    output logic             o_push,
    output t_rec             o_rec
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [CW:0]    wid;
    logic [RW:0]    hgt;
    logic           accept;
    logic           wrap;
    logic [CW-1:0]  c0;
    logic [RW-1:0]  r0;
    logic           c_last, r_last;
    t_rec           rec0;
    logic           int0;

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;

    logic               r1_v, r2_v, r3_v;
    logic [CW-1:0]      r1_addr;
    logic [PIX_W-1:0]   r1_pix;
    t_rec               r1_rec, r2_rec, r3_rec;
    logic               r1_int, r2_int, r3_int;

    logic [PIX_W-1:0]   r_pa [3];
    logic [PIX_W-1:0]   r_pb [3];
    logic [PIX_W-1:0]   nc [3];
    logic [SUM_W-1:0]   s_left, s_right, s_top, s_bot;
    logic [SUM_W-1:0]   ax, ay;
    logic [SUM_W-1:0]   r2_ax, r2_ay;
    logic [SQ_W-1:0]    r3_sx, r3_sy;
    logic [SQ_W:0]      mag2;
    logic [2*THR_W-1:0] r_thr_sq;
    logic [QCW:0]       used;

    always_comb begin
        if (int'(i_cfg.frame_width) < MIN_SIZE) begin
            wid = (CW+1)'(MIN_SIZE);
        end else if (int'(i_cfg.frame_width) > MAX_WIDTH) begin
            wid = (CW+1)'(MAX_WIDTH);
        end else begin
            wid = (CW+1)'(i_cfg.frame_width);
        end
        if (int'(i_cfg.frame_height) < MIN_SIZE) begin
            hgt = (RW+1)'(MIN_SIZE);
        end else if (int'(i_cfg.frame_height) > MAX_HEIGHT) begin
            hgt = (RW+1)'(MAX_HEIGHT);
        end else begin
            hgt = (RW+1)'(i_cfg.frame_height);
        end
    end

    // reserve queue room for every pixel still in flight
    assign used    = {1'b0, i_qstat.count} + (QCW+1)'(r1_v) + (QCW+1)'(r2_v)
                   + (QCW+1)'(r3_v);
    assign o_stall = (int'(used) >= QDEPTH);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        wrap   = ({1'b0, r_col} >= wid) || ({1'b0, r_row} >= hgt);
        c0     = wrap ? '0 : r_col;
        r0     = wrap ? '0 : r_row;
        c_last = ({1'b0, c0} == wid - 1'b1);
        r_last = ({1'b0, r0} == hgt - 1'b1);
        int0   = (int'(c0) >= 2) && (int'(r0) >= 2);

        rec0.col      = COL_W'(c0);
        rec0.row      = ROW_W'(r0);
        rec0.edge_hit = 1'b0;
        rec0.has_prev = (r0 != '0) && (c0 != '0);
        rec0.has_edge = (r0 != '0) && c_last;
        rec0.has_last = r_last;
        rec0.last_px  = r_last && c_last;

        if (c_last) begin
            n_col = '0;
            n_row = r_last ? '0 : r0 + 1'b1;
        end else begin
            n_col = c0 + 1'b1;
            n_row = r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // line store word: upper row in the high byte, lower row in the low byte
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[c0];
        end
        if (r1_v) begin
            r_mem[r1_addr] <= {r_rd[PIX_W-1:0], r1_pix};
        end
    end

    always_comb begin
        nc[0] = r_rd[2*PIX_W-1:PIX_W];
        nc[1] = r_rd[PIX_W-1:0];
        nc[2] = r1_pix;

        s_left  = SUM_W'(r_pb[0]) + {1'b0, r_pb[1], 1'b0} + SUM_W'(r_pb[2]);
        s_right = SUM_W'(nc[0])   + {1'b0, nc[1], 1'b0}   + SUM_W'(nc[2]);
        s_top   = SUM_W'(r_pb[0]) + {1'b0, r_pa[0], 1'b0} + SUM_W'(nc[0]);
        s_bot   = SUM_W'(r_pb[2]) + {1'b0, r_pa[2], 1'b0} + SUM_W'(nc[2]);

        ax = (s_left >= s_right) ? s_left - s_right : s_right - s_left;
        ay = (s_bot >= s_top) ? s_bot - s_top : s_top - s_bot;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_addr <= c0;
            r1_pix  <= i_pixel_value;
            r1_rec  <= rec0;
            r1_int  <= int0;
        end
        if (r1_v) begin
            r_pb   <= r_pa;
            r_pa   <= nc;
        end
        r2_ax    <= ax;
        r2_ay    <= ay;
        r2_rec   <= r1_rec;
        r2_int   <= r1_int;
        r3_sx    <= SQ_W'(r2_ax) * SQ_W'(r2_ax);
        r3_sy    <= SQ_W'(r2_ay) * SQ_W'(r2_ay);
        r3_rec   <= r2_rec;
        r3_int   <= r2_int;
        r_thr_sq <= (2*THR_W)'(i_cfg.edge_threshold) * (2*THR_W)'(i_cfg.edge_threshold);
    end

    always_comb begin
        mag2           = {1'b0, r3_sx} + {1'b0, r3_sy};
        o_rec          = r3_rec;
        o_rec.edge_hit = r3_int && (mag2 >= (SQ_W+1)'(r_thr_sq));
        o_push         = r3_v && (r3_rec.has_prev || r3_rec.has_edge || r3_rec.has_last);
    end

endmodule

`default_nettype wire

/* src/sebs_queue.sv */
// Record queue between front and back end, register based.
// Depends on sebs_pkg for the record type and depth.
`default_nettype none

module sebs_queue
    import sebs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_rec,
    input  logic   i_pop,
    output t_rec   o_head,
    output t_qstat o_qstat
);

    t_rec           r_ent [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_rec;
        end
    end

    assign o_head         = r_ent[r_rp];
    assign o_qstat.count  = r_cnt;
    assign o_qstat.nempty = (r_cnt != '0);

endmodule

`default_nettype wire

/* src/sebs_back.sv */
// Back end: expands each record into its results and holds the output register.
// Depends on sebs_pkg for the record and pick types.
`default_nettype none

module sebs_back
    import sebs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rec             i_head,
    input  t_qstat           i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_edge_value,
    output logic [COL_W-1:0] o_out_column,
    output logic [ROW_W-1:0] o_out_row,
    output logic             o_frame_last
);

    logic [2:0]       r_done;
    logic [2:0]       pend;
    logic [2:0]       pick_bit;
    logic             final_one;
    logic             load;
    t_pick            pick;
    logic             r_ov;
    logic [PIX_W-1:0] r_edge, n_edge;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_last, n_last;

    always_comb begin
        pend      = {i_head.has_last, i_head.has_edge, i_head.has_prev} & ~r_done;
        final_one = ((pend & (pend - 3'd1)) == 3'd0);
        if (pend[0]) begin
            pick = PICK_PREV;
        end else if (pend[1]) begin
            pick = PICK_EDGE;
        end else begin
            pick = PICK_LAST;
        end

        unique case (pick)
            PICK_PREV: begin
                pick_bit = 3'b001;
                n_edge   = i_head.edge_hit ? EDGE_ON : EDGE_OFF;
                n_col    = i_head.col - 1'b1;
                n_row    = i_head.row - 1'b1;
                n_last   = 1'b0;
            end
            PICK_EDGE: begin
                pick_bit = 3'b010;
                n_edge   = EDGE_OFF;
                n_col    = i_head.col;
                n_row    = i_head.row - 1'b1;
                n_last   = 1'b0;
            end
            PICK_LAST: begin
                pick_bit = 3'b100;
                n_edge   = EDGE_OFF;
                n_col    = i_head.col;
                n_row    = i_head.row;
                n_last   = i_head.last_px;
            end
            default: begin
                pick_bit = 3'b000;
                n_edge   = EDGE_OFF;
                n_col    = i_head.col;
                n_row    = i_head.row;
                n_last   = 1'b0;
            end
        endcase

        load  = i_qstat.nempty && (!r_ov || !i_stall);
        o_pop = load && final_one;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_done <= '0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | pick_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_edge <= n_edge;
            r_col  <= n_col;
            r_row  <= n_row;
            r_last <= n_last;
        end
    end

    assign o_valid      = r_ov;
    assign o_edge_value = r_edge;
    assign o_out_column = r_col;
    assign o_out_row    = r_row;
    assign o_frame_last = r_last;

endmodule

`default_nettype wire

/* tb/sv/sebs_edge_checker.sv */
// Checker for the binarized Sobel edge stream: tracks register writes and pixel items,
// predicts edge results in raster order and compares them with the block's output.
// Depends on sebs_pkg for field widths, register indexes and reset values.
module sebs_edge_checker
    import sebs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              i_pix_valid,
    input  logic              i_pix_stall,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic              i_edge_valid,
    input  logic              i_edge_stall,
    input  logic [PIX_W-1:0]  i_edge_value,
    input  logic [COL_W-1:0]  i_out_column,
    input  logic [ROW_W-1:0]  i_out_row,
    input  logic              i_frame_last,
    output int                o_fail_count,
    output int                o_edges_pending
);

    localparam int REPORT_CAP = 50;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } edge_px_t;

    t_cfg             cfg;
    logic [PIX_W-1:0] upper_row [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] lower_row [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    int unsigned      col_pos;
    int unsigned      row_pos;
    edge_px_t         edges_due [$];
    int               fails = 0;

    initial begin
        for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
            upper_row[k] = '0;
            lower_row[k] = '0;
        end
    end

    function automatic logic [PIX_W-1:0] sobel_mark();
        int gx;
        int gy;
        int t;
        gx = (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]))
           - (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        t = int'(cfg.edge_threshold);
        return (gx * gx + gy * gy >= t * t) ? EDGE_ON : EDGE_OFF;
    endfunction

    function automatic void advance_raster(logic [PIX_W-1:0] pix);
        int unsigned      wid;
        int unsigned      hgt;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] v;
        wid = (cfg.frame_width < MIN_SIZE) ? MIN_SIZE :
              (cfg.frame_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg.frame_width;
        hgt = (cfg.frame_height < MIN_SIZE) ? MIN_SIZE :
              (cfg.frame_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg.frame_height;
        if (col_pos >= wid || row_pos >= hgt) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        above = upper_row[c];
        mid = lower_row[c];
        win[0] = win[1];
        win[1] = win[2];
        win[2] = above;
        win[3] = win[4];
        win[4] = win[5];
        win[5] = mid;
        win[6] = win[7];
        win[7] = win[8];
        win[8] = pix;
        upper_row[c] = mid;
        lower_row[c] = pix;
        if (r >= 1) begin
            if (c >= 1) begin
                v = (c >= 2 && r >= 2) ? sobel_mark() : EDGE_OFF;
                edges_due.push_back('{v, COL_W'(c - 1), ROW_W'(r - 1), 1'b0});
            end
            if (c == wid - 1)
                edges_due.push_back('{EDGE_OFF, COL_W'(c), ROW_W'(r - 1), 1'b0});
        end
        if (r == hgt - 1)
            edges_due.push_back('{EDGE_OFF, COL_W'(c), ROW_W'(r), (c == wid - 1)});
        if (c + 1 >= wid) begin
            col_pos = 0;
            row_pos = (r + 1 >= hgt) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic flag_field(string name, int unsigned want, int unsigned got);
        if (fails < REPORT_CAP)
            $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
    endtask

    always @(posedge i_clk) begin
        edge_px_t want;
        if (!i_rst_n) begin
            cfg = '{THR_RESET, WIDTH_RESET, HEIGHT_RESET};
            for (int k = 0; k < 9; k++)
                win[k] = '0;
            col_pos = 0;
            row_pos = 0;
            edges_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_THRESHOLD: cfg.edge_threshold = pwdata[THR_W-1:0];
                    REG_WIDTH:     cfg.frame_width = pwdata[FW_W-1:0];
                    REG_HEIGHT:    cfg.frame_height = pwdata[FH_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && !i_pix_stall)
                advance_raster(i_pixel_value);
            if (i_edge_valid && !i_edge_stall) begin
                if (edges_due.size() == 0) begin
                    if (fails < REPORT_CAP)
                        $error("unexpected result at column %0d row %0d",
                               i_out_column, i_out_row);
                    fails++;
                end else begin
                    want = edges_due.pop_front();
                    if (i_edge_value !== want.value)
                        flag_field("edge_value", want.value, i_edge_value);
                    if (i_out_column !== want.col)
                        flag_field("out_column", want.col, i_out_column);
                    if (i_out_row !== want.row)
                        flag_field("out_row", want.row, i_out_row);
                    if (i_frame_last !== want.last)
                        flag_field("frame_last", want.last, i_frame_last);
                end
            end
        end
        o_edges_pending <= edges_due.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the Sobel edge stream testbench: clock, reset, register writes, pixel
// stimulus with random gaps and output stalls, and the final verdict.
// Depends on sebs_pkg, sobel_edge_binarize_stream and sebs_edge_checker.
module tb_top;
    import sebs_pkg::*;

    localparam int REG_UNMAPPED = 3;
    localparam int RANDOM_ITEMS = 150;

    typedef enum int {
        TEX_NOISE,
        TEX_FLAT,
        TEX_CHECKER,
        TEX_RAMP
    } t_texture;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [PIX_W-1:0]  i_pixel_value = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [PIX_W-1:0]  o_edge_value;
    logic [COL_W-1:0]  o_out_column;
    logic [ROW_W-1:0]  o_out_row;
    logic              o_frame_last;

    int                fail_count;
    int                edges_pending;
    bit                calm = 1'b0;
    int unsigned       burst_left = 0;
    int unsigned       cur_w = 3;
    int unsigned       cur_h = 3;

    sobel_edge_binarize_stream u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_edge_value  (o_edge_value),
        .o_out_column  (o_out_column),
        .o_out_row     (o_out_row),
        .o_frame_last  (o_frame_last)
    );

    sebs_edge_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .i_pix_valid     (i_valid),
        .i_pix_stall     (o_stall),
        .i_pixel_value   (i_pixel_value),
        .i_edge_valid    (o_valid),
        .i_edge_stall    (i_stall),
        .i_edge_value    (o_edge_value),
        .i_out_column    (o_out_column),
        .i_out_row       (o_out_row),
        .i_frame_last    (o_frame_last),
        .o_fail_count    (fail_count),
        .o_edges_pending (edges_pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned hold;
        int unsigned pick;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    i_stall <= 1'b0;
                    hold = $urandom_range(1, 8);
                end else if (pick < 80) begin
                    i_stall <= 1'b0;
                    hold = $urandom_range(20, 60);
                end else if (pick < 95 || calm) begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(1, 3);
                end else begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(10, 40);
                end
            end
            hold--;
        end
    end

    function automatic int unsigned sender_gap();
        int unsigned pick;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            burst_left = $urandom_range(10, 50);
            return 0;
        end
        if (pick < 55)
            return 0;
        if (pick < 92 || calm)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [PIX_W-1:0] texture_pixel(t_texture tex, int unsigned c,
                                                       int unsigned r);
        int unsigned v;
        case (tex)
            TEX_FLAT: v = 96 + $urandom_range(0, 15);
            TEX_CHECKER: begin
                v = (((c / 2) + (r / 2)) % 2) ? 255 : 0;
                if ($urandom_range(0, 15) == 0)
                    v = 255 - v;
            end
            TEX_RAMP: v = c * 29 + r * 53 + $urandom_range(0, 7);
            default: v = $urandom_range(0, 255);
        endcase
        return PIX_W'(v);
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (edges_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic apb_write(input int unsigned idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_regs(input int unsigned thr, input int unsigned w,
                                input int unsigned h);
        wait_drained();
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        cur_w = (w < MIN_SIZE) ? MIN_SIZE : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        cur_h = (h < MIN_SIZE) ? MIN_SIZE : (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
    endtask

    task automatic send_frame(input t_texture tex, input bit pauses);
        int unsigned c;
        int unsigned r;
        for (r = 0; r < cur_h; r++) begin
            for (c = 0; c < cur_w; c++) begin
                if (pauses && $urandom_range(0, 99) == 0) begin
                    wait_drained();
                    if ($urandom_range(0, 1) == 1)
                        apb_write(REG_THRESHOLD, $urandom_range(0, 255));
                end
                send_pixel(texture_pixel(tex, c, r));
            end
        end
    endtask

    // start of a frame only, in raster order
    task automatic send_pixels(input t_texture tex, input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            send_pixel(texture_pixel(tex, k % cur_w, k / cur_w));
    endtask

    initial begin
        int unsigned i;
        int unsigned random_sent;
        int unsigned waited;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero threshold, undersized width and height clamp to 3x3
        program_regs(0, 1, 0);
        for (i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? 8'h00 : 8'hFF);
        wait_drained();
        apb_write(REG_UNMAPPED, $urandom());

        // full threshold against the steepest vertical step
        program_regs(255, 3, 2);
        for (i = 0; i < 9; i++)
            send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);

        // shrink the width mid-frame so the position falls outside the frame
        program_regs(128, 6, 3);
        for (i = 0; i < 9; i++)
            send_pixel(texture_pixel(TEX_NOISE, 0, 0));
        program_regs(128, 3, 4);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            send_frame(t_texture'($urandom_range(0, 3)), 1'b1);
            random_sent += cur_w * cur_h;
            program_regs(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255),
                         $urandom_range(0, 12), $urandom_range(1, 6));
        end

        // oversized width and height clamp to the maximum; send a frame start only
        calm = 1'b1;
        program_regs($urandom_range(0, 255), 4095, 0);
        send_pixels(TEX_NOISE, 24);
        program_regs($urandom_range(0, 255), 2, 8191);
        send_pixels(t_texture'($urandom_range(0, 3)), 12);
        calm = 1'b0;

        i_valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (edges_pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (edges_pending != 0)
            $error("%0d results never arrived", edges_pending);
        if (fail_count == 0 && edges_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
